@@ hdl/rtte_pkg.sv @@
// Package of shared types and constants for the retransmit timeout estimator.
package rtte_pkg;

    localparam int RTT_BITS  = 24;
    localparam int RTO_BITS  = 32;
    localparam int CLAMP_W   = 16;
    localparam int MAXR_W    = 8;
    localparam int CNT_W     = MAXR_W + 1;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    localparam logic [CLAMP_W-1:0] RST_RTO_MIN    = 16'd1000;
    localparam logic [CLAMP_W-1:0] RST_RTO_MAX    = 16'd3000;
    localparam logic [MAXR_W-1:0]  RST_MAX_RETX   = 8'd12;
    localparam logic [CLAMP_W-1:0] RST_INIT_VAR   = 16'd750;
    localparam logic [RTO_BITS-1:0] RST_RTO       = 32'd3000;

    localparam logic [CFG_IDX_W-1:0] CFG_RTO_MIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RTO_MAX   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RETX  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_VAR  = 3'd3;

    typedef enum logic [1:0] {
        REQ_INIT       = 2'd0,
        REQ_NEW_PKT    = 2'd1,
        REQ_RTT_SAMPLE = 2'd2,
        REQ_TIMEOUT    = 2'd3
    } t_req_type;

endpackage

@@ hdl/rtte_req_if.sv @@
// Event request channel: valid/ready handshake with event type and measured RTT.
interface rtte_req_if
    import rtte_pkg::*;
();
    logic                valid;
    logic                ready;
    t_req_type           req_type;
    logic [23:0]         measured_rtt_ms;

    modport source (output valid, output req_type, output measured_rtt_ms, input ready);
    modport sink   (input valid, input req_type, input measured_rtt_ms, output ready);
endinterface

@@ hdl/rtte_res_if.sv @@
// Result channel: valid/ready handshake with timeout, give-up flag and estimates.
interface rtte_res_if
    import rtte_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [RTO_BITS-1:0] rto_ms;
    logic                give_up;
    logic [23:0]         smoothed_rtt_ms;
    logic [23:0]         rtt_deviation_ms;

    modport source (output valid, output rto_ms, output give_up, output smoothed_rtt_ms,
                    output rtt_deviation_ms, input ready);
    modport sink   (input valid, input rto_ms, input give_up, input smoothed_rtt_ms,
                    input rtt_deviation_ms, output ready);
endinterface

@@ hdl/rtt_estimator_rto.sv @@
// Retransmit timeout estimator top level.
//
// Channels: i_req carries one event per transaction (init, new packet, RTT
// sample, timeout) with the measured RTT; o_res returns one result per event:
// the retransmit timeout, the give-up flag, smoothed RTT and mean deviation
// after that event. The configuration port writes min/max clamp, the
// retransmit limit and the initial deviation; write only while idle.
// Latency: the result is valid the cycle after the event transaction.
// Throughput: one event per cycle, set by the single update stage that
// reads and writes the estimator state in the same cycle.
// The result register frees itself when o_res is taken, so a new event is
// accepted in the same cycle the previous result leaves. If the receiver
// stalls, the result holds and i_req.ready drops until it is taken.
// Reset (synchronous, active low): srtt 0, deviation 750 ms, timeout
// 3000 ms, retransmit count 0, registers to their defaults, no result.
module rtt_estimator_rto
    import rtte_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    rtte_req_if.sink             i_req,
    rtte_res_if.source           o_res
);

    localparam int SUM_W = RTT_BITS + 3;

    logic [CLAMP_W-1:0]  r_rto_min;
    logic [CLAMP_W-1:0]  r_rto_max;
    logic [MAXR_W-1:0]   r_max_retx;
    logic [CLAMP_W-1:0]  r_init_var;

    logic [RTT_BITS-1:0] r_srtt;
    logic [RTT_BITS-1:0] r_rttvar;
    logic [RTO_BITS-1:0] r_rto;
    logic [CNT_W-1:0]    r_count;

    logic                r_out_valid;
    logic [RTO_BITS-1:0] r_out_rto;
    logic                r_out_give_up;
    logic [RTT_BITS-1:0] r_out_srtt;
    logic [RTT_BITS-1:0] r_out_rttvar;

    logic [RTT_BITS-1:0] n_srtt;
    logic [RTT_BITS-1:0] n_rttvar;
    logic [RTO_BITS-1:0] n_rto;
    logic [CNT_W-1:0]    n_count;

    logic                accept;
    logic [RTT_BITS-1:0] rtt;
    logic [RTT_BITS-1:0] dev;
    logic [SUM_W-1:0]    srtt_acc;
    logic [SUM_W-1:0]    var_acc;
    logic [RTT_BITS-1:0] smp_srtt;
    logic [RTT_BITS-1:0] smp_var;
    logic [RTT_BITS-1:0] clamp_var;
    logic [RTT_BITS-1:0] clamp_srtt;
    logic [SUM_W-1:0]    rto_sum;
    logic [CLAMP_W-1:0]  rto_clamped;

    assign i_req.ready = !r_out_valid || o_res.ready;
    assign accept      = i_req.valid && i_req.ready;
    assign rtt         = RTT_BITS'(i_req.measured_rtt_ms);

    always_comb begin
        dev      = (rtt >= r_srtt) ? (rtt - r_srtt) : (r_srtt - rtt);
        srtt_acc = (SUM_W'(r_srtt) << 3) - SUM_W'(r_srtt) + SUM_W'(rtt);
        var_acc  = (SUM_W'(r_rttvar) << 1) + SUM_W'(r_rttvar) + SUM_W'(dev);
        smp_srtt = srtt_acc[RTT_BITS+2:3];
        smp_var  = var_acc[RTT_BITS+1:2];

        if (i_req.req_type == REQ_INIT) begin
            clamp_srtt = '0;
            clamp_var  = RTT_BITS'(r_init_var);
        end else begin
            clamp_srtt = smp_srtt;
            clamp_var  = smp_var;
        end

        rto_sum = SUM_W'(clamp_srtt) + (SUM_W'(clamp_var) << 2);
        if (rto_sum < SUM_W'(r_rto_min)) begin
            rto_clamped = r_rto_min;
        end else if (rto_sum > SUM_W'(r_rto_max)) begin
            rto_clamped = r_rto_max;
        end else begin
            rto_clamped = rto_sum[CLAMP_W-1:0];
        end

        n_srtt   = r_srtt;
        n_rttvar = r_rttvar;
        n_rto    = r_rto;
        n_count  = r_count;
        case (i_req.req_type)
            REQ_INIT: begin
                n_srtt   = clamp_srtt;
                n_rttvar = clamp_var;
                n_rto    = RTO_BITS'(rto_clamped);
            end
            REQ_NEW_PKT: begin
                n_count = '0;
            end
            REQ_RTT_SAMPLE: begin
                n_srtt   = clamp_srtt;
                n_rttvar = clamp_var;
                n_rto    = RTO_BITS'(rto_clamped);
            end
            REQ_TIMEOUT: begin
                n_rto = r_rto[RTO_BITS-1] ? '1 : (r_rto << 1);
                if (r_count <= CNT_W'(r_max_retx)) begin
                    n_count = r_count + CNT_W'(1);
                end
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rto_min  <= RST_RTO_MIN;
            r_rto_max  <= RST_RTO_MAX;
            r_max_retx <= RST_MAX_RETX;
            r_init_var <= RST_INIT_VAR;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_RTO_MIN:  r_rto_min  <= i_cfg_data;
                CFG_RTO_MAX:  r_rto_max  <= i_cfg_data;
                CFG_MAX_RETX: r_max_retx <= i_cfg_data[MAXR_W-1:0];
                CFG_INIT_VAR: r_init_var <= i_cfg_data;
                default: begin
                    r_rto_min <= r_rto_min;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_srtt      <= '0;
            r_rttvar    <= RTT_BITS'(RST_INIT_VAR);
            r_rto       <= RST_RTO;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_srtt      <= n_srtt;
                r_rttvar    <= n_rttvar;
                r_rto       <= n_rto;
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_rto     <= n_rto;
            r_out_give_up <= (n_count > CNT_W'(r_max_retx));
            r_out_srtt    <= n_srtt;
            r_out_rttvar  <= n_rttvar;
        end
    end

    assign o_res.valid            = r_out_valid;
    assign o_res.rto_ms           = r_out_rto;
    assign o_res.give_up          = r_out_give_up;
    assign o_res.smoothed_rtt_ms  = 24'(r_out_srtt);
    assign o_res.rtt_deviation_ms = 24'(r_out_rttvar);

endmodule
